// ===== rtl/ppts_pkg.sv =====
package ppts_pkg;

  // Table geometry
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  // Beat field widths
  localparam int OP_W    = 3;
  localparam int FSLOT_W = 4;
  localparam int PRIO_W  = 4;
  localparam int STAT_W  = 2;
  localparam int MAXR_W  = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [MAXR_W-1:0] MAX_RUN_RESET = MAXR_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT  = 3'd0,
    OP_STOP   = 3'd1,
    OP_KILL   = 3'd2,
    OP_RESUME = 3'd3,
    OP_DONE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_READY = 2'd1,
    ST_STOP  = 2'd2,
    ST_TERM  = 2'd3
  } slot_st_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOT_ADM = 2'd1,
    STAT_TERM    = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_PLACE,
    S_DISPATCH,
    S_SCAN,
    S_PREEMPT,
    S_DONE
  } fsm_t;

  // One slot table entry
  typedef struct packed {
    slot_st_t          st;
    logic [PRIO_W-1:0] prio;
  } slot_ent_t;

  // Sequencer to compare unit
  typedef struct packed {
    logic              clear;
    logic              step;
    logic              worst;   // 1: worst running, 0: best ready
    slot_ent_t         ent;
    logic [SLOT_W-1:0] idx;
  } pick_ctl_t;

  // Compare unit to sequencer
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [PRIO_W-1:0] prio;
  } pick_res_t;

  // Slot index to the fixed 4-bit beat field
  function automatic logic [FSLOT_W-1:0] to_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+FSLOT_W-1:0] ext;
    ext = {{FSLOT_W{1'b0}}, s};
    return ext[FSLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/ppts_pick.sv =====
module ppts_pick (
  input  logic                clk,
  input  logic                rst_n,
  input  ppts_pkg::pick_ctl_t ctl,
  output ppts_pkg::pick_res_t res
);

  logic                        found_r, found_nxt;
  logic [ppts_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic [ppts_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic                        st_hit, better, take;

  // Shared compare: state match, then priority against the running best
  always_comb begin
    st_hit = ctl.worst ? (ctl.ent.st == ppts_pkg::ST_RUN) : (ctl.ent.st == ppts_pkg::ST_READY);
    better = ctl.worst ? (ctl.ent.prio > prio_r) : (ctl.ent.prio < prio_r);
    take   = ctl.step && st_hit && (!found_r || better);
    found_nxt = found_r;
    idx_nxt   = idx_r;
    prio_nxt  = prio_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
      idx_nxt   = ctl.idx;
      prio_nxt  = ctl.ent.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r  <= idx_nxt;
    prio_r <= prio_nxt;
  end

  assign res.found = found_r;
  assign res.idx   = idx_r;
  assign res.prio  = prio_r;

endmodule

// ===== rtl/preemptive_priority_task_scheduler_top.sv =====
// Preemptive priority task scheduler.
// Input channel in_*: one command beat; in_tuser carries the op, in_tdata the
// slot and the priority. Result channel out_*: exactly one result beat per
// command. cfg_wr_en/cfg_wr_data set max_running (zero acts as one); write it
// only while no command is in flight.
// Commands are handled one at a time by a small sequencer around a slot table
// with a single read port and one shared compare unit. A command that needs
// a scan (admit or resume with all run slots taken, or stop/kill/completion
// of a running task) walks the admitted slots one per cycle. in_tready is
// high only while the sequencer idles, so a new command is not taken before
// the result of the last one goes valid. The result sits in an output
// register; while an earlier beat still waits there, the sequencer holds the
// finished result and takes no new command until that beat goes.
// Reset (rst_n low, synchronous) empties the table, zeroes the admitted and
// running counts and sets max_running to 3; the table needs no clearing pass.
module preemptive_priority_task_scheduler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ppts_pkg::IN_DATA_W-1:0]    in_tdata,   // task_slot[3:0], task_priority[7:4]
  input  logic [ppts_pkg::OP_W-1:0]         in_tuser,   // op[2:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], admitted_slot[5:2], started_valid[6], started_slot[10:7],
  // preempted_valid[11], preempted_slot[15:12]
  output logic [ppts_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [ppts_pkg::MAXR_W-1:0]       cfg_wr_data
);

  localparam int SW = ppts_pkg::SLOT_W;
  localparam int CW = ppts_pkg::CNT_W;
  localparam int PW = ppts_pkg::PRIO_W;

  ppts_pkg::fsm_t state_r, state_nxt;
  ppts_pkg::op_t  op_r, op_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [ppts_pkg::FSLOT_W-1:0] in_slot_r, in_slot_nxt;
  logic [PW-1:0]  prio_r, prio_nxt;
  logic [CW-1:0]  lim_r, lim_nxt;
  logic [CW-1:0]  adm_cnt_r, adm_cnt_nxt;
  logic [CW-1:0]  run_cnt_r, run_cnt_nxt;
  logic [ppts_pkg::MAXR_W-1:0] max_run_r;
  logic           worst_r, worst_nxt;
  logic [CW-1:0]  scan_idx_r, scan_idx_nxt;
  logic           pend_r, pend_nxt;
  logic [SW-1:0]  pend_idx_r, pend_idx_nxt;

  ppts_pkg::status_t res_status_r, res_status_nxt;
  logic [SW-1:0]  res_adm_r, res_adm_nxt;
  logic           res_st_v_r, res_st_v_nxt;
  logic [SW-1:0]  res_st_r, res_st_nxt;
  logic           res_pre_v_r, res_pre_v_nxt;
  logic [SW-1:0]  res_pre_r, res_pre_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [ppts_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Slot table
  ppts_pkg::slot_ent_t mem_r [ppts_pkg::TASK_SLOTS];
  ppts_pkg::slot_ent_t rd_data_r;
  ppts_pkg::slot_ent_t mem_wdata;
  logic [SW-1:0]       mem_waddr, rd_addr;
  logic                mem_we;

  ppts_pkg::pick_ctl_t pick_ctl;
  ppts_pkg::pick_res_t pick_res;

  logic [ppts_pkg::MAXR_W-1:0] cap;
  logic run_full, scan_issue, accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ppts_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cap        = (max_run_r == '0) ? ppts_pkg::MAXR_W'(1) : max_run_r;
  assign run_full   = int'(run_cnt_r) >= int'(cap);
  assign scan_issue = scan_idx_r < lim_r;

  ppts_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pick_ctl),
    .res   (pick_res)
  );

  // Sequencer: next state, table accesses and result build-up
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    in_slot_nxt    = in_slot_r;
    prio_nxt       = prio_r;
    lim_nxt        = lim_r;
    adm_cnt_nxt    = adm_cnt_r;
    run_cnt_nxt    = run_cnt_r;
    worst_nxt      = worst_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_adm_nxt    = res_adm_r;
    res_st_v_nxt   = res_st_v_r;
    res_st_nxt     = res_st_r;
    res_pre_v_nxt  = res_pre_v_r;
    res_pre_nxt    = res_pre_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = slot_r;
    mem_wdata      = '{st: ppts_pkg::ST_RUN, prio: prio_r};
    rd_addr        = slot_r;
    pick_ctl       = '{clear: 1'b0, step: pend_r, worst: worst_r,
                       ent: rd_data_r, idx: pend_idx_r};

    // Output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ppts_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt         = ppts_pkg::op_t'(in_tuser);
          in_slot_nxt    = in_tdata[ppts_pkg::FSLOT_W-1:0];
          slot_nxt       = SW'(in_tdata[ppts_pkg::FSLOT_W-1:0]);
          prio_nxt       = in_tdata[ppts_pkg::FSLOT_W +: PW];
          res_status_nxt = ppts_pkg::STAT_OK;
          res_adm_nxt    = '0;
          res_st_v_nxt   = 1'b0;
          res_st_nxt     = '0;
          res_pre_v_nxt  = 1'b0;
          res_pre_nxt    = '0;
          state_nxt      = ppts_pkg::S_DECODE;
        end
      end

      ppts_pkg::S_DECODE: begin
        // table read of slot_r is issued here for the non-admit ops
        case (op_r)
          ppts_pkg::OP_ADMIT: begin
            if (int'(adm_cnt_r) >= ppts_pkg::TASK_SLOTS) begin
              res_status_nxt = ppts_pkg::STAT_FULL;
              state_nxt      = ppts_pkg::S_DONE;
            end else begin
              slot_nxt    = adm_cnt_r[SW-1:0];
              res_adm_nxt = adm_cnt_r[SW-1:0];
              lim_nxt     = adm_cnt_r;
              adm_cnt_nxt = adm_cnt_r + CW'(1);
              state_nxt   = ppts_pkg::S_PLACE;
            end
          end
          ppts_pkg::OP_STOP, ppts_pkg::OP_KILL, ppts_pkg::OP_RESUME,
          ppts_pkg::OP_DONE: begin
            if (int'(in_slot_r) >= int'(adm_cnt_r)) begin
              res_status_nxt = ppts_pkg::STAT_NOT_ADM;
              state_nxt      = ppts_pkg::S_DONE;
            end else begin
              state_nxt = ppts_pkg::S_CHECK;
            end
          end
          default: begin
            state_nxt = ppts_pkg::S_DONE;
          end
        endcase
      end

      ppts_pkg::S_CHECK: begin
        if (rd_data_r.st == ppts_pkg::ST_TERM) begin
          res_status_nxt = ppts_pkg::STAT_TERM;
          state_nxt      = ppts_pkg::S_DONE;
        end else if (op_r == ppts_pkg::OP_RESUME) begin
          if (rd_data_r.st == ppts_pkg::ST_RUN) begin
            state_nxt = ppts_pkg::S_DONE;
          end else begin
            prio_nxt  = rd_data_r.prio;
            lim_nxt   = adm_cnt_r;
            state_nxt = ppts_pkg::S_PLACE;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = '{st: (op_r == ppts_pkg::OP_STOP) ? ppts_pkg::ST_STOP : ppts_pkg::ST_TERM,
                        prio: rd_data_r.prio};
          if (rd_data_r.st == ppts_pkg::ST_RUN) begin
            if (run_cnt_r != '0) begin
              run_cnt_nxt = run_cnt_r - CW'(1);
            end
            state_nxt = ppts_pkg::S_DISPATCH;
          end else begin
            state_nxt = ppts_pkg::S_DONE;
          end
        end
      end

      ppts_pkg::S_PLACE: begin
        if (!run_full) begin
          mem_we       = 1'b1;
          run_cnt_nxt  = run_cnt_r + CW'(1);
          res_st_v_nxt = 1'b1;
          res_st_nxt   = slot_r;
          state_nxt    = ppts_pkg::S_DONE;
        end else begin
          worst_nxt      = 1'b1;
          scan_idx_nxt   = '0;
          pick_ctl.clear = 1'b1;
          state_nxt      = ppts_pkg::S_SCAN;
        end
      end

      ppts_pkg::S_DISPATCH: begin
        if (run_full) begin
          state_nxt = ppts_pkg::S_DONE;
        end else begin
          worst_nxt      = 1'b0;
          lim_nxt        = adm_cnt_r;
          scan_idx_nxt   = '0;
          pick_ctl.clear = 1'b1;
          state_nxt      = ppts_pkg::S_SCAN;
        end
      end

      ppts_pkg::S_SCAN: begin
        // read one slot a cycle, compare it the cycle after
        rd_addr = scan_idx_r[SW-1:0];
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[SW-1:0];
        end else if (!pend_r) begin
          if (worst_r) begin
            if (pick_res.found && (prio_r < pick_res.prio)) begin
              mem_we        = 1'b1;
              mem_waddr     = pick_res.idx;
              mem_wdata     = '{st: ppts_pkg::ST_READY, prio: pick_res.prio};
              res_pre_v_nxt = 1'b1;
              res_pre_nxt   = pick_res.idx;
              state_nxt     = ppts_pkg::S_PREEMPT;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{st: ppts_pkg::ST_READY, prio: prio_r};
              state_nxt = ppts_pkg::S_DONE;
            end
          end else begin
            if (pick_res.found) begin
              mem_we       = 1'b1;
              mem_waddr    = pick_res.idx;
              mem_wdata    = '{st: ppts_pkg::ST_RUN, prio: pick_res.prio};
              run_cnt_nxt  = run_cnt_r + CW'(1);
              res_st_v_nxt = 1'b1;
              res_st_nxt   = pick_res.idx;
            end
            state_nxt = ppts_pkg::S_DONE;
          end
        end
      end

      ppts_pkg::S_PREEMPT: begin
        mem_we       = 1'b1;
        res_st_v_nxt = 1'b1;
        res_st_nxt   = slot_r;
        state_nxt    = ppts_pkg::S_DONE;
      end

      ppts_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ppts_pkg::to_field(res_pre_r), res_pre_v_r,
                           ppts_pkg::to_field(res_st_r), res_st_v_r,
                           ppts_pkg::to_field(res_adm_r), res_status_r};
          state_nxt     = ppts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ppts_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppts_pkg::S_IDLE;
      adm_cnt_r   <= '0;
      run_cnt_r   <= '0;
      max_run_r   <= ppts_pkg::MAX_RUN_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      adm_cnt_r   <= adm_cnt_nxt;
      run_cnt_r   <= run_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_wr_en) begin
        max_run_r <= cfg_wr_data;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    in_slot_r    <= in_slot_nxt;
    prio_r       <= prio_nxt;
    lim_r        <= lim_nxt;
    worst_r      <= worst_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_adm_r    <= res_adm_nxt;
    res_st_v_r   <= res_st_v_nxt;
    res_st_r     <= res_st_nxt;
    res_pre_v_r  <= res_pre_v_nxt;
    res_pre_r    <= res_pre_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Checks
  assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= adm_cnt_r)
    else $error("running count exceeds admitted count");

  assert property (@(posedge clk) disable iff (!rst_n)
    int'(adm_cnt_r) <= ppts_pkg::TASK_SLOTS)
    else $error("admitted count beyond table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppts_pkg::S_IDLE) |-> !pend_r)
    else $error("scan read pending while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[11]) |-> (out_data_r[6] && out_data_r[1:0] == ppts_pkg::STAT_OK
                                         && out_data_r[10:7] != out_data_r[15:12]))
    else $error("preemption without a distinct started task");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import ppts_pkg::*;

  // Op codes the block does not decode
  localparam logic [OP_W-1:0] OP_RSV5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSV6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSV7 = 3'd7;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 154;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 50;
  localparam int LIVE_FLOOR   = 8;

  // run limits per phase: extremes, zero (acts as one), every bit toggled
  localparam logic [MAXR_W-1:0] LIMITS [PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd2, 5'd31, 5'd4, 5'd8, 5'd3
  };

  // Result beat, lowest field last
  typedef struct packed {
    logic [FSLOT_W-1:0] preempted_slot;
    logic               preempted_valid;
    logic [FSLOT_W-1:0] started_slot;
    logic               started_valid;
    logic [FSLOT_W-1:0] admitted_slot;
    status_t            status;
  } sched_res_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FSLOT_W-1:0] slot;
    logic [PRIO_W-1:0]  prio;
    bit                 typed;
    sched_res_t         res;
  } cmd_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;   // task_slot[3:0], task_priority[7:4]
  logic [OP_W-1:0]       in_tuser    = '0;   // op[2:0]
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // status[1:0], admitted_slot[5:2], started_valid[6], started_slot[10:7],
  // preempted_valid[11], preempted_slot[15:12]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [MAXR_W-1:0]     cfg_wr_data = '0;

  preemptive_priority_task_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scheduler shadow: slot table, counts and run limit
  slot_st_t          task_state [TASK_SLOTS];
  logic [PRIO_W-1:0] task_prio  [TASK_SLOTS];
  int                admitted_tasks = 0;
  int                running_tasks  = 0;
  logic [MAXR_W-1:0] run_limit      = MAX_RUN_RESET;

  sched_res_t expected_results [$];
  cmd_row_t   directed_rows [$];

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int preemptions     = 0;
  int starts          = 0;
  int status_mix [4]  = '{0, 0, 0, 0};
  int cycle_count     = 0;

  function automatic int run_cap();
    return (run_limit == '0) ? 1 : int'(run_limit);
  endfunction

  // Least urgent running task, lowest slot on ties
  function automatic int worst_running_slot();
    int w = -1;
    for (int i = 0; i < admitted_tasks; i++)
      if (task_state[i] == ST_RUN && (w < 0 || task_prio[i] > task_prio[w]))
        w = i;
    return w;
  endfunction

  // Most urgent ready task, lowest slot on ties
  function automatic int best_ready_slot();
    int b = -1;
    for (int i = 0; i < admitted_tasks; i++)
      if (task_state[i] == ST_READY && (b < 0 || task_prio[i] < task_prio[b]))
        b = i;
    return b;
  endfunction

  // Run the task, preempt the worst runner, or leave it ready
  function automatic void place_task(input int s, inout sched_res_t r);
    int w;
    if (running_tasks < run_cap()) begin
      task_state[s] = ST_RUN;
      running_tasks++;
      r.started_valid = 1'b1;
      r.started_slot  = FSLOT_W'(s);
    end else begin
      w = worst_running_slot();
      if (w >= 0 && task_prio[s] < task_prio[w]) begin
        task_state[w]     = ST_READY;
        task_state[s]     = ST_RUN;
        r.started_valid   = 1'b1;
        r.started_slot    = FSLOT_W'(s);
        r.preempted_valid = 1'b1;
        r.preempted_slot  = FSLOT_W'(w);
      end else begin
        task_state[s] = ST_READY;
      end
    end
  endfunction

  function automatic void dispatch_ready(inout sched_res_t r);
    int b;
    if (running_tasks < run_cap()) begin
      b = best_ready_slot();
      if (b >= 0) begin
        task_state[b] = ST_RUN;
        running_tasks++;
        r.started_valid = 1'b1;
        r.started_slot  = FSLOT_W'(b);
      end
    end
  endfunction

  function automatic sched_res_t schedule(input logic [OP_W-1:0] op,
                                          input logic [FSLOT_W-1:0] slot,
                                          input logic [PRIO_W-1:0] prio);
    sched_res_t r;
    bit         was_running;
    int         s;
    r = '0;
    case (op)
      OP_ADMIT: begin
        if (admitted_tasks >= TASK_SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          s = admitted_tasks;
          admitted_tasks++;
          task_prio[s]    = prio;
          r.admitted_slot = FSLOT_W'(s);
          place_task(s, r);
        end
      end
      OP_STOP, OP_KILL, OP_RESUME, OP_DONE: begin
        s = int'(slot);
        if (s >= admitted_tasks) begin
          r.status = STAT_NOT_ADM;
        end else if (task_state[s] == ST_TERM) begin
          r.status = STAT_TERM;
        end else begin
          was_running = (task_state[s] == ST_RUN);
          if (op == OP_RESUME) begin
            if (!was_running) place_task(s, r);
          end else begin
            task_state[s] = (op == OP_STOP) ? ST_STOP : ST_TERM;
            if (was_running) begin
              if (running_tasks > 0) running_tasks--;
              dispatch_ready(r);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sched_res_t mk_res(input status_t st, input int adm, input bit sv,
                                        input int ss, input bit pv, input int ps);
    sched_res_t r;
    r.status          = st;
    r.admitted_slot   = FSLOT_W'(adm);
    r.started_valid   = sv;
    r.started_slot    = FSLOT_W'(ss);
    r.preempted_valid = pv;
    r.preempted_slot  = FSLOT_W'(ps);
    return r;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input int slot, input int prio,
                         input bit typed, input sched_res_t res);
    cmd_row_t row;
    row.op    = op;
    row.slot  = FSLOT_W'(slot);
    row.prio  = PRIO_W'(prio);
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Random command, mostly well formed and aimed at admitted slots
  function automatic void pick_command(output logic [OP_W-1:0] op,
                                       output logic [FSLOT_W-1:0] slot,
                                       output logic [PRIO_W-1:0] prio);
    int roll;
    int live;
    int start;
    int idx;
    bit found;
    live = 0;
    for (int i = 0; i < admitted_tasks; i++)
      if (task_state[i] != ST_TERM) live++;
    prio = PRIO_W'($urandom);
    slot = FSLOT_W'($urandom);
    roll = $urandom_range(99);
    if ((admitted_tasks < TASK_SLOTS) ? (roll < 45) : (roll < 4)) begin
      op = OP_ADMIT;
    end else if (roll >= 96) begin
      op = OP_W'($urandom_range(OP_RSV7, OP_RSV5));
    end else begin
      roll = $urandom_range(99);
      if (roll < 40)      op = OP_STOP;
      else if (roll < 44) op = OP_KILL;
      else if (roll < 48) op = OP_DONE;
      else                op = OP_RESUME;
      if (admitted_tasks > 0 && $urandom_range(9) != 0) begin
        slot = FSLOT_W'($urandom_range(admitted_tasks - 1));
        // stops and ends hit a running task half the time
        if (op != OP_RESUME && $urandom_range(1) == 1) begin
          start = $urandom_range(admitted_tasks - 1);
          found = 1'b0;
          for (int k = 0; k < admitted_tasks; k++) begin
            idx = (start + k) % admitted_tasks;
            if (!found && task_state[idx] == ST_RUN) begin
              slot  = FSLOT_W'(idx);
              found = 1'b1;
            end
          end
        end
      end
      // terminations cannot be undone, so keep a working set alive
      if ((op == OP_KILL || op == OP_DONE) && live <= LIVE_FLOOR &&
          int'(slot) < admitted_tasks && task_state[slot] != ST_TERM)
        op = OP_STOP;
    end
  endfunction

  // Offer one command beat; the prediction is taken at the accepting edge
  task automatic send_command(input logic [OP_W-1:0] op, input logic [FSLOT_W-1:0] slot,
                              input logic [PRIO_W-1:0] prio, input bit typed,
                              input sched_res_t typed_res);
    sched_res_t predicted;
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {prio, slot};
    do @(posedge clk); while (!in_tready);
    predicted = schedule(op, slot, prio);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Drain, then write the run limit while the block idles
  task automatic set_run_limit(input logic [MAXR_W-1:0] v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    run_limit = v;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_CAP)
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
    errors++;
  endtask

  task automatic check_result(input sched_res_t got, input sched_res_t want);
    if (got.status !== want.status)
      report_mismatch("status", int'(got.status), int'(want.status));
    if (got.admitted_slot !== want.admitted_slot)
      report_mismatch("admitted_slot", int'(got.admitted_slot), int'(want.admitted_slot));
    if (got.started_valid !== want.started_valid)
      report_mismatch("started_valid", int'(got.started_valid), int'(want.started_valid));
    if (got.started_slot !== want.started_slot)
      report_mismatch("started_slot", int'(got.started_slot), int'(want.started_slot));
    if (got.preempted_valid !== want.preempted_valid)
      report_mismatch("preempted_valid", int'(got.preempted_valid),
                      int'(want.preempted_valid));
    if (got.preempted_slot !== want.preempted_slot)
      report_mismatch("preempted_slot", int'(got.preempted_slot),
                      int'(want.preempted_slot));
    status_mix[want.status]++;
    preemptions += int'(want.preempted_valid);
    starts      += int'(want.started_valid);
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0)
        report_mismatch("result beat with nothing pending, out_tdata", int'(out_tdata), 0);
      else
        check_result(sched_res_t'(out_tdata), expected_results.pop_front());
      results_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stuck: %0d results still pending after %0d cycles",
               expected_results.size(), cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [FSLOT_W-1:0] slot;
    logic [PRIO_W-1:0]  prio;

    // Directed commands from an empty table, run limit at its reset value
    add_row(OP_STOP,   15, 0,  1, mk_res(STAT_NOT_ADM, 0, 0, 0, 0, 0)); // nothing admitted
    add_row(OP_RSV7,   15, 15, 1, mk_res(STAT_OK, 0, 0, 0, 0, 0));      // undecoded op
    add_row(OP_ADMIT,  0,  15, 1, mk_res(STAT_OK, 0, 1, 0, 0, 0));
    add_row(OP_ADMIT,  0,  0,  1, mk_res(STAT_OK, 1, 1, 1, 0, 0));
    add_row(OP_ADMIT,  0,  8,  1, mk_res(STAT_OK, 2, 1, 2, 0, 0));
    add_row(OP_RESUME, 3,  0,  1, mk_res(STAT_NOT_ADM, 0, 0, 0, 0, 0)); // first free slot
    add_row(OP_ADMIT,  0,  4,  0, '0);  // run slots full: preempts the worst
    add_row(OP_ADMIT,  0,  4,  0, '0);
    add_row(OP_ADMIT,  0,  15, 0, '0);  // not better than any runner: ready
    add_row(OP_RESUME, 1,  0,  0, '0);  // already running
    add_row(OP_STOP,   1,  0,  0, '0);  // frees a run slot, dispatches
    add_row(OP_STOP,   5,  0,  0, '0);  // ready task stopped
    add_row(OP_KILL,   5,  0,  0, '0);  // stopped task killed, no dispatch
    add_row(OP_KILL,   5,  0,  1, mk_res(STAT_TERM, 0, 0, 0, 0, 0));
    add_row(OP_RESUME, 5,  0,  1, mk_res(STAT_TERM, 0, 0, 0, 0, 0));
    add_row(OP_DONE,   5,  0,  1, mk_res(STAT_TERM, 0, 0, 0, 0, 0));
    add_row(OP_STOP,   5,  0,  1, mk_res(STAT_TERM, 0, 0, 0, 0, 0));
    add_row(OP_RESUME, 1,  0,  0, '0);  // stopped task back, may preempt
    add_row(OP_DONE,   3,  0,  0, '0);
    add_row(OP_RSV5,   0,  0,  1, mk_res(STAT_OK, 0, 0, 0, 0, 0));
    add_row(OP_RSV6,   9,  9,  1, mk_res(STAT_OK, 0, 0, 0, 0, 0));
    add_row(OP_ADMIT,  0,  4,  0, '0);  // priority ties
    add_row(OP_DONE,   0,  0,  0, '0);
    add_row(OP_KILL,   2,  0,  0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_command(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].prio,
                   directed_rows[i].typed, directed_rows[i].res);

    // Random phases, each under its own run limit
    for (int phase = 0; phase < PHASES; phase++) begin
      set_run_limit(LIMITS[phase]);
      calm = (phase == 3);
      if (phase == 5) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        pick_command(op, slot, prio);
        send_command(op, slot, prio, 1'b0, '0);
      end
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d commands over %0d run limits; %0d results checked, %0d starts, %0d preemptions",
             items_sent, PHASES, results_checked, starts, preemptions);
    $display("status mix ok/not admitted/terminated/full: %0d/%0d/%0d/%0d, %0d mismatches",
             status_mix[0], status_mix[1], status_mix[2], status_mix[3], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
